[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the dial reporter checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked during reset
`define AQDR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("aqdr check failed");

// next-cycle implication, masked during reset
`define AQDR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("aqdr check failed");

// next-cycle implication, also checked while reset is applied
`define AQDR_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("aqdr reset check failed");

`endif

[rtl/aqdr_pkg.sv]
// ---------------------------------------------------------------------------
// aqdr_pkg
// Types and fixed constants of the analog quadrature dial reporter.
// ---------------------------------------------------------------------------
package aqdr_pkg;

  typedef logic signed [1:0] level_t;

  localparam level_t LVL_NEG  = -2'sd1;
  localparam level_t LVL_ZERO = 2'sd0;
  localparam level_t LVL_POS  = 2'sd1;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  localparam logic [1:0] REG_UPPER  = 2'd0;
  localparam logic [1:0] REG_LOWER  = 2'd1;
  localparam logic [1:0] REG_CENTER = 2'd2;

  localparam logic [11:0] UPPER_RESET  = 12'd2670;
  localparam logic [11:0] LOWER_RESET  = 12'd1602;
  localparam logic [11:0] CENTER_RESET = 12'd2048;

  localparam int ACC_LIMIT   = 32767;
  localparam int CHUNK_LIMIT = 4095;

endpackage

[rtl/analog_quadrature_dial_reporter.sv]
// ---------------------------------------------------------------------------
// analog_quadrature_dial_reporter: analog quadrature dial with rotation reports
// Pipeline: a report beat is registered in stage 1, then out_valid and the report are registered
// when it advances; samples give no beat. Throughput: one beat per cycle while the output is not stalled.
// Reset (synchronous, active low) restores thresholds, clears level, accumulator, stages.
// ---------------------------------------------------------------------------
module analog_quadrature_dial_reporter #(
  parameter int CLICK_TENTHS     = 75,
  parameter int CHUNKS_PER_CLICK = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_kind,
  input  logic [11:0]        in_sample_a,
  input  logic [11:0]        in_sample_b,
  input  logic               in_button_pressed,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_button,
  output logic signed [12:0] out_rotation,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int NUM_MAX = 32767 * CHUNKS_PER_CLICK + CLICK_TENTHS - 1;
  localparam int NUM_W   = $clog2(NUM_MAX + 1);
  localparam int DEN_W   = $clog2(CLICK_TENTHS);
  localparam int SHIFT   = NUM_W + DEN_W;
  localparam longint RECIP = ((64'sd1 <<< SHIFT) + CLICK_TENTHS - 1) / CLICK_TENTHS;
  localparam int RECIP_W = $clog2(RECIP + 1);
  localparam int PROD_W  = NUM_W + RECIP_W;
  localparam int Q_W     = PROD_W - SHIFT;
  localparam int Q_X     = (Q_W > 13) ? Q_W : 13;
  localparam logic signed [16:0] CLICK = 17'(CLICK_TENTHS);

  function automatic logic signed [15:0] sat_acc(input logic signed [16:0] v);
    logic signed [15:0] res;
    if (v > 17'sd32767) begin
      res = 16'(aqdr_pkg::ACC_LIMIT);
    end else if (v < -17'sd32767) begin
      res = -16'(aqdr_pkg::ACC_LIMIT);
    end else begin
      res = v[15:0];
    end
    return res;
  endfunction

  logic [11:0] upper_r, lower_r, center_r;
  logic        cfg_wr;

  logic        s1_valid_r, s1_kind_r, s1_btn_r;
  logic [11:0] s1_a_r, s1_b_r;
  logic        s1_adv;

  logic               out_valid_r, out_valid_nxt;
  logic               out_button_r;
  logic signed [12:0] out_rotation_r;

  aqdr_pkg::level_t   level_r, level_nxt, lvl_smp, sign_b;
  logic signed [15:0] acc_r, acc_nxt, acc_neg;

  logic [14:0]         mag;
  logic [NUM_W-1:0]    num;
  logic [PROD_W-1:0]   prod;
  logic [Q_X-1:0]      quot_x;
  logic [11:0]         qmag;
  logic signed [12:0]  chunk_pos, chunk;
  logic signed [16:0]  acc_smp;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_r  <= aqdr_pkg::UPPER_RESET;
      lower_r  <= aqdr_pkg::LOWER_RESET;
      center_r <= aqdr_pkg::CENTER_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        aqdr_pkg::REG_UPPER:  upper_r  <= pwdata[11:0];
        aqdr_pkg::REG_LOWER:  lower_r  <= pwdata[11:0];
        aqdr_pkg::REG_CENTER: center_r <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      aqdr_pkg::REG_UPPER:  prdata = {20'd0, upper_r};
      aqdr_pkg::REG_LOWER:  prdata = {20'd0, lower_r};
      aqdr_pkg::REG_CENTER: prdata = {20'd0, center_r};
      default:              prdata = 32'd0;
    endcase
  end

  // handshake
  assign s1_adv   = s1_valid_r & ((s1_kind_r == aqdr_pkg::KIND_SAMPLE) | ~out_valid_r | out_ready);
  assign in_ready = ~s1_valid_r | s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_kind_r <= in_kind;
      s1_a_r    <= in_sample_a;
      s1_b_r    <= in_sample_b;
      s1_btn_r  <= in_button_pressed;
    end
  end

  // chunk of the current accumulator: ceil(|acc| * C / U) by reciprocal multiply
  assign acc_neg   = -acc_r;
  assign mag       = acc_r[15] ? acc_neg[14:0] : acc_r[14:0];
  assign num       = NUM_W'(mag) * NUM_W'(CHUNKS_PER_CLICK) + NUM_W'(CLICK_TENTHS - 1);
  assign prod      = PROD_W'(num) * PROD_W'(RECIP);
  assign quot_x    = Q_X'(prod[PROD_W-1:SHIFT]);
  assign qmag      = (quot_x > Q_X'(aqdr_pkg::CHUNK_LIMIT)) ? 12'(aqdr_pkg::CHUNK_LIMIT)
                                                             : quot_x[11:0];
  assign chunk_pos = $signed({1'b0, qmag});
  assign chunk     = acc_r[15] ? -chunk_pos : chunk_pos;

  // sample decode
  always_comb begin
    lvl_smp = level_r;
    if (s1_a_r > upper_r) lvl_smp = aqdr_pkg::LVL_POS;
    if (s1_a_r < lower_r) lvl_smp = aqdr_pkg::LVL_NEG;
    sign_b = aqdr_pkg::LVL_ZERO;
    if (s1_b_r > center_r) sign_b = aqdr_pkg::LVL_POS;
    if (s1_b_r < center_r) sign_b = aqdr_pkg::LVL_NEG;
    acc_smp = 17'(acc_r);
    if (lvl_smp != level_r) begin
      if (lvl_smp == sign_b) begin
        acc_smp = 17'(acc_r) - CLICK;
      end else if (lvl_smp == -sign_b) begin
        acc_smp = 17'(acc_r) + CLICK;
      end
    end
  end

  always_comb begin
    level_nxt     = level_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    if (s1_adv) begin
      if (s1_kind_r == aqdr_pkg::KIND_SAMPLE) begin
        level_nxt = lvl_smp;
        acc_nxt   = sat_acc(acc_smp);
      end else begin
        acc_nxt       = sat_acc(17'(acc_r) - 17'(chunk));
        out_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= aqdr_pkg::LVL_ZERO;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      level_r     <= level_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && (s1_kind_r == aqdr_pkg::KIND_REPORT)) begin
      out_button_r   <= s1_btn_r;
      out_rotation_r <= chunk;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_button   = out_button_r;
  assign out_rotation = out_rotation_r;

endmodule

[rtl/aqdr_checker.sv]
// ---------------------------------------------------------------------------
// aqdr_checker
// Port-level checks of the dial reporter, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module aqdr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_button,
  input logic signed [12:0] out_rotation,
  input logic               pready
);

  `AQDR_ASSERT_RST(a_reset_empty, !rst_n, !out_valid && in_ready)
  `AQDR_ASSERT_NOW(a_chunk_range, out_valid, out_rotation <= 13'sd4095 && out_rotation >= -13'sd4095)
  `AQDR_ASSERT_NOW(a_pready_high, 1'b1, pready)
  `AQDR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_rotation) && $stable(out_button))

endmodule

bind analog_quadrature_dial_reporter aqdr_checker u_aqdr_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_button   (out_button),
  .out_rotation (out_rotation),
  .pready       (pready)
);

[verif/analog_quadrature_dial_reporter_tb.sv]
// ---------------------------------------------------------------------------
// analog_quadrature_dial_reporter_tb
// Self-checking bench for the dial reporter. A short directed table is
// followed by random phases with different threshold settings, including
// crossed and extreme thresholds and long runs of clicks in one direction
// that drive the accumulator into saturation. An in-bench model of the
// level, the accumulator and the rounding predicts each unpinned report;
// the sender idles in bursts and the receiver stalls on its own pattern.
// ---------------------------------------------------------------------------
module analog_quadrature_dial_reporter_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int UNITS      = 75;
  localparam int CHUNKS     = 5;
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_LEN   = 300;

  typedef struct packed {
    logic               button;
    logic signed [12:0] rotation;
  } dial_report_t;

  typedef struct packed {
    logic               kind;
    logic [11:0]        a;
    logic [11:0]        b;
    logic               btn;
    logic               pinned;
    logic signed [12:0] rot;
  } dial_row_t;

  localparam dial_row_t DIRECTED [0:19] = '{
    '{aqdr_pkg::KIND_REPORT, 12'd0,    12'd0,    1'b0, 1'b1, 13'sd0},
    '{aqdr_pkg::KIND_REPORT, 12'd4095, 12'd4095, 1'b1, 1'b1, 13'sd0},
    '{aqdr_pkg::KIND_SAMPLE, 12'd4095, 12'd4095, 1'b1, 1'b0, 13'sd0},
    '{aqdr_pkg::KIND_REPORT, 12'd4095, 12'd0,    1'b0, 1'b1, -13'sd5},
    '{aqdr_pkg::KIND_SAMPLE, 12'd0,    12'd0,    1'b0, 1'b0, 13'sd0},
    '{aqdr_pkg::KIND_SAMPLE, 12'd0,    12'd4095, 1'b0, 1'b0, 13'sd0},
    '{aqdr_pkg::KIND_SAMPLE, 12'd2000, 12'd0,    1'b1, 1'b0, 13'sd0},
    '{aqdr_pkg::KIND_SAMPLE, 12'd2670, 12'd0,    1'b0, 1'b0, 13'sd0},
    '{aqdr_pkg::KIND_SAMPLE, 12'd1602, 12'd0,    1'b0, 1'b0, 13'sd0},
    '{aqdr_pkg::KIND_SAMPLE, 12'd2671, 12'd2048, 1'b0, 1'b0, 13'sd0},
    '{aqdr_pkg::KIND_SAMPLE, 12'd1601, 12'd4095, 1'b0, 1'b0, 13'sd0},
    '{aqdr_pkg::KIND_SAMPLE, 12'd4095, 12'd0,    1'b0, 1'b0, 13'sd0},
    '{aqdr_pkg::KIND_REPORT, 12'd1234, 12'd3210, 1'b1, 1'b0, 13'sd0},
    '{aqdr_pkg::KIND_REPORT, 12'd0,    12'd0,    1'b0, 1'b0, 13'sd0},
    '{aqdr_pkg::KIND_SAMPLE, 12'd0,    12'd2049, 1'b1, 1'b0, 13'sd0},
    '{aqdr_pkg::KIND_SAMPLE, 12'd4095, 12'd2047, 1'b0, 1'b0, 13'sd0},
    '{aqdr_pkg::KIND_REPORT, 12'd0,    12'd0,    1'b1, 1'b0, 13'sd0},
    '{aqdr_pkg::KIND_SAMPLE, 12'd4095, 12'd4095, 1'b0, 1'b0, 13'sd0},
    '{aqdr_pkg::KIND_SAMPLE, 12'd0,    12'd4095, 1'b0, 1'b0, 13'sd0},
    '{aqdr_pkg::KIND_REPORT, 12'd0,    12'd0,    1'b0, 1'b0, 13'sd0}
  };

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_kind;
  logic [11:0]        in_sample_a;
  logic [11:0]        in_sample_b;
  logic               in_button_pressed;
  logic               out_valid;
  logic               out_ready;
  logic               out_button;
  logic signed [12:0] out_rotation;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  logic [11:0]      upper_thr;
  logic [11:0]      lower_thr;
  logic [11:0]      center_thr;
  aqdr_pkg::level_t dial_level;
  int               rot_acc;
  int               drift_dir;
  dial_report_t     report_q [$];
  int               err_count = 0;
  int               burst_left = 0;
  int               idle_cycles = 0;
  bit               hold_req = 1'b0;

  analog_quadrature_dial_reporter #(
    .CLICK_TENTHS    (UNITS),
    .CHUNKS_PER_CLICK(CHUNKS)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_sample_a      (in_sample_a),
    .in_sample_b      (in_sample_b),
    .in_button_pressed(in_button_pressed),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_button       (out_button),
    .out_rotation     (out_rotation),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // Advance the dial state by one beat; a report tick yields a report.
  task automatic advance_dial(input logic kind, input logic [11:0] a, input logic [11:0] b,
                              input logic btn, output bit has_report,
                              output dial_report_t rpt);
    int nxt;
    int sgn;
    int mag;
    int quo;
    int chunk;
    has_report = 1'b0;
    rpt = '0;
    if (kind == aqdr_pkg::KIND_SAMPLE) begin
      nxt = int'(dial_level);
      sgn = 0;
      if (a > upper_thr) nxt = 1;
      if (a < lower_thr) nxt = -1;
      if (b > center_thr) sgn = 1;
      if (b < center_thr) sgn = -1;
      if (nxt != int'(dial_level)) begin
        if (nxt == sgn) rot_acc -= UNITS;
        else if (nxt == -sgn) rot_acc += UNITS;
      end
      if (rot_acc > aqdr_pkg::ACC_LIMIT) rot_acc = aqdr_pkg::ACC_LIMIT;
      if (rot_acc < -aqdr_pkg::ACC_LIMIT) rot_acc = -aqdr_pkg::ACC_LIMIT;
      dial_level = aqdr_pkg::level_t'(nxt);
    end else begin
      mag = (rot_acc < 0) ? -rot_acc : rot_acc;
      quo = (mag * CHUNKS + UNITS - 1) / UNITS;
      chunk = (rot_acc < 0) ? -quo : quo;
      if (chunk > aqdr_pkg::CHUNK_LIMIT) chunk = aqdr_pkg::CHUNK_LIMIT;
      if (chunk < -aqdr_pkg::CHUNK_LIMIT) chunk = -aqdr_pkg::CHUNK_LIMIT;
      rot_acc -= chunk;
      if (rot_acc > aqdr_pkg::ACC_LIMIT) rot_acc = aqdr_pkg::ACC_LIMIT;
      if (rot_acc < -aqdr_pkg::ACC_LIMIT) rot_acc = -aqdr_pkg::ACC_LIMIT;
      has_report = 1'b1;
      rpt.button = btn;
      rpt.rotation = 13'(chunk);
    end
  endtask

  task automatic send_beat(input logic kind, input logic [11:0] a, input logic [11:0] b,
                           input logic btn, input logic pinned,
                           input logic signed [12:0] pin_rot);
    int gap;
    bit has_report;
    dial_report_t rpt;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_kind <= kind;
    in_sample_a <= a;
    in_sample_b <= b;
    in_button_pressed <= btn;
    do @(posedge clk); while (!in_ready);
    advance_dial(kind, a, b, btn, has_report, rpt);
    if (has_report) begin
      if (pinned) begin
        rpt.button = btn;
        rpt.rotation = pin_rot;
      end
      report_q.push_back(rpt);
    end
  endtask

  // Drop valid and wait until every report has come back.
  task automatic settle_block();
    if (in_valid) in_valid <= 1'b0;
    burst_left = 0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [11:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (!wr && prdata[11:0] !== val) report_mismatch("register readback", prdata[11:0], val);
  endtask

  task automatic program_thresholds(input logic [11:0] up, input logic [11:0] lo,
                                    input logic [11:0] ce);
    apb_access(1'b1, aqdr_pkg::REG_UPPER, up);
    apb_access(1'b1, aqdr_pkg::REG_LOWER, lo);
    apb_access(1'b1, aqdr_pkg::REG_CENTER, ce);
    upper_thr = up;
    lower_thr = lo;
    center_thr = ce;
    apb_access(1'b0, aqdr_pkg::REG_UPPER, up);
    apb_access(1'b0, aqdr_pkg::REG_LOWER, lo);
    apb_access(1'b0, aqdr_pkg::REG_CENTER, ce);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [11:0] pick_above(input logic [11:0] thr);
    if (thr == 12'hFFF) return 12'hFFF;
    return 12'($urandom_range(4095, int'(thr) + 1));
  endfunction

  function automatic logic [11:0] pick_below(input logic [11:0] thr);
    if (thr == 12'h000) return 12'h000;
    return 12'($urandom_range(int'(thr) - 1, 0));
  endfunction

  // One random beat: mostly clean clicks, some reports, some noise.
  task automatic send_random(input int sat_dir, input bit tail);
    int roll;
    int dir;
    int target;
    int sgn;
    logic [11:0] a;
    logic [11:0] b;
    roll = $urandom_range(0, 99);
    a = 12'($urandom);
    b = 12'($urandom);
    if (sat_dir != 0 && !tail) roll = 99;
    if (roll < 22) begin
      send_beat(aqdr_pkg::KIND_REPORT, a, b, 1'($urandom), 1'b0, '0);
    end else if (roll < 37) begin
      if ($urandom_range(0, 2) == 0 && lower_thr <= upper_thr)
        a = 12'($urandom_range(int'(upper_thr), int'(lower_thr)));
      if ($urandom_range(0, 4) == 0) b = center_thr;
      send_beat(aqdr_pkg::KIND_SAMPLE, a, b, 1'($urandom), 1'b0, '0);
    end else begin
      if ($urandom_range(0, 99) < 3) drift_dir = -drift_dir;
      dir = (sat_dir != 0) ? sat_dir : drift_dir;
      target = (dial_level == aqdr_pkg::LVL_POS) ? -1 : 1;
      sgn = (dir > 0) ? -target : target;
      a = (target > 0) ? pick_above(upper_thr) : pick_below(lower_thr);
      b = (sgn > 0) ? pick_above(center_thr) : pick_below(center_thr);
      if (sat_dir == 0 && $urandom_range(0, 19) == 0) b = center_thr;
      send_beat(aqdr_pkg::KIND_SAMPLE, a, b, 1'($urandom), 1'b0, '0);
    end
  endtask

  task automatic run_phase(input logic [11:0] up, input logic [11:0] lo, input logic [11:0] ce,
                           input int count, input int sat_dir, input int hold_at,
                           input int pause_at);
    settle_block();
    program_thresholds(up, lo, ce);
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_req <= 1'b1;
      if (i == pause_at) settle_block();
      send_random(sat_dir, i >= count - 40);
    end
  endtask

  // Receiver: shifting stall patterns, plus one long hold on request.
  initial begin
    int cnt;
    int rx_mode;
    logic [15:0] rx_pattern;
    cnt = 0;
    rx_mode = 0;
    rx_pattern = '1;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req <= 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end else begin
        if (cnt % 64 == 0) begin
          rx_mode = $urandom_range(0, 3);
          rx_pattern = 16'($urandom);
        end
        case (rx_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= rx_pattern[cnt % 16];
          2: out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= 1'($urandom);
        endcase
        cnt++;
      end
    end
  end

  always @(posedge clk) begin
    dial_report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (report_q.size() == 0) begin
        report_mismatch("report with none pending", int'(out_rotation), 0);
      end else begin
        want = report_q.pop_front();
        if (out_button !== want.button)
          report_mismatch("button", out_button, want.button);
        if (out_rotation !== want.rotation)
          report_mismatch("rotation", int'(out_rotation), int'(want.rotation));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = aqdr_pkg::KIND_SAMPLE;
    in_sample_a = '0;
    in_sample_b = '0;
    in_button_pressed = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    upper_thr = aqdr_pkg::UPPER_RESET;
    lower_thr = aqdr_pkg::LOWER_RESET;
    center_thr = aqdr_pkg::CENTER_RESET;
    dial_level = aqdr_pkg::LVL_ZERO;
    rot_acc = 0;
    drift_dir = 1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i])
      send_beat(DIRECTED[i].kind, DIRECTED[i].a, DIRECTED[i].b, DIRECTED[i].btn,
                DIRECTED[i].pinned, DIRECTED[i].rot);

    run_phase(aqdr_pkg::UPPER_RESET, aqdr_pkg::LOWER_RESET, aqdr_pkg::CENTER_RESET,
              200, 0, 100, -1);
    run_phase(12'($urandom_range(2048, 4094)), 12'($urandom_range(1, 2047)),
              12'($urandom_range(1, 4094)), 200, 0, -1, 100);
    run_phase(aqdr_pkg::UPPER_RESET, aqdr_pkg::LOWER_RESET, aqdr_pkg::CENTER_RESET,
              480, 1, -1, -1);
    run_phase(12'd0, 12'd4095, 12'd0, 150, 0, -1, -1);
    run_phase(12'd4095, 12'd0, 12'd4095, 120, 0, -1, -1);
    run_phase(12'd3000, 12'd1000, 12'd2048, 480, -1, -1, -1);

    settle_block();
    repeat (8) @(posedge clk);
    if (err_count == 0 && report_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/aqdr_pkg.sv
rtl/analog_quadrature_dial_reporter.sv
rtl/aqdr_checker.sv
verif/analog_quadrature_dial_reporter_tb.sv
